>>> src/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared constants and types of the keypad code lock
// Sizes, button positions, result codes and the control structures that
// pass between the entry keeper and the slot scanner.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Sizes of the code store and of one entry.
  localparam int CODE_SLOTS  = 8;
  localparam int CODE_DIGITS = 4;
  localparam int SLOT_W      = $clog2(CODE_SLOTS);
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int ENTRY_W     = 4 * CODE_DIGITS;

  // Keypad scan layout.
  localparam int BTN_W          = 12;
  localparam int NUM_DIGIT_KEYS = 10;
  localparam int BTN_ENTER      = 10;
  localparam int BTN_CLEAR      = 11;

  // Result field widths.
  localparam int LED_W     = 4;
  localparam int VERDICT_W = 2;

  // Enter presses on an empty entry that switch enroll mode on and off.
  localparam int PRESS_W                 = 4;
  localparam logic [PRESS_W-1:0] PRESS_ENROLL_ON  = PRESS_W'(5);
  localparam logic [PRESS_W-1:0] PRESS_ENROLL_OFF = PRESS_W'(10);

  // Factory code held in slot zero until it is overwritten.
  localparam logic [ENTRY_W-1:0] INIT_CODE = {CODE_DIGITS{4'h1}};

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_MATCH  = 2'd1,
    VERDICT_REJECT = 2'd2
  } kcl_verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } kcl_state_t;

  // What one accepted item asks of the scanner.
  typedef struct packed {
    logic [LED_W-1:0] led;
    logic             enroll;
    logic             check;
  } kcl_step_t;

  // Entry and slot bookkeeping that the scanner compares against.
  typedef struct packed {
    logic [ENTRY_W-1:0]    entry;
    logic [CODE_SLOTS-1:0] valid;
    logic                  slot0_written;
  } kcl_slots_t;

endpackage

>>> src/kcl_if.sv
// ----------------------------------------------------------------------------
// kcl_in_if / kcl_out_if: item channels of the keypad code lock
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface kcl_in_if import kcl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

interface kcl_out_if import kcl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LED_W-1:0]     led;
  logic [VERDICT_W-1:0] verdict;
  logic                 enroll_active;

  modport source (output valid, output led, output verdict, output enroll_active,
                  input ready);
  modport sink   (input valid, input led, input verdict, input enroll_active,
                  output ready);
endinterface

>>> src/kcl_ram.sv
// ----------------------------------------------------------------------------
// kcl_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/kcl_entry.sv
// ----------------------------------------------------------------------------
// kcl_entry: keypad decode, entry buffer and mode bookkeeping
// Decodes one scan, updates the entry, press count, enroll mode, blink and
// slot bookkeeping on each accepted item, and writes enrolled codes.
// ----------------------------------------------------------------------------
module kcl_entry import kcl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [BTN_W-1:0]   buttons,
  output kcl_step_t          step,
  output kcl_slots_t         slots,
  output logic               wr_en,
  output logic [SLOT_W-1:0]  wr_addr,
  output logic [ENTRY_W-1:0] wr_data
);

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_DIGIT,
    KEY_CLEAR,
    KEY_ENTER
  } key_kind_t;

  key_kind_t             key_kind;
  logic [3:0]            key_digit;

  logic [ENTRY_W-1:0]    entry_r,     entry_nxt;
  logic [CNT_W-1:0]      count_r,     count_nxt;
  logic [PRESS_W-1:0]    presses_r,   presses_nxt;
  logic                  enroll_r,    enroll_nxt;
  logic                  blink_r,     blink_nxt;
  logic [SLOT_W-1:0]     next_slot_r, next_slot_nxt;
  logic [CODE_SLOTS-1:0] valid_r,     valid_nxt;
  logic                  slot0_wr_r,  slot0_wr_nxt;

  logic                  empty;
  logic                  full;
  logic                  store;
  logic [PRESS_W-1:0]    presses_inc;
  logic [CNT_W+1:0]      count_m1;
  logic [LED_W-1:0]      led_pat;
  logic [LED_W-1:0]      led;

  // Priority decode: lowest digit key, then clear, then enter.
  always_comb begin
    key_kind  = KEY_NONE;
    key_digit = '0;
    if (buttons[BTN_ENTER]) begin
      key_kind = KEY_ENTER;
    end
    if (buttons[BTN_CLEAR]) begin
      key_kind = KEY_CLEAR;
    end
    for (int i = NUM_DIGIT_KEYS - 1; i >= 0; i--) begin
      if (buttons[i]) begin
        key_kind  = KEY_DIGIT;
        key_digit = 4'(i);
      end
    end
  end

  assign empty       = (count_r == '0);
  assign full        = (count_r == CNT_W'(CODE_DIGITS));
  assign presses_inc = presses_r + PRESS_W'(1);
  assign count_m1    = {2'b00, count_r} - (CNT_W+2)'(1);

  // LED pattern reflects the state before this item.
  assign led_pat = {~enroll_r, 1'b1, (empty ? 2'b11 : count_m1[1:0])};

  // Blink: with a non-empty entry the LED is dark on every other item.
  always_comb begin
    blink_nxt = blink_r;
    led       = led_pat;
    if (!empty) begin
      blink_nxt = ~blink_r;
      if (blink_r) begin
        led = '0;
      end
    end
  end

  // Entry, press count and slot bookkeeping.
  always_comb begin
    entry_nxt     = entry_r;
    count_nxt     = count_r;
    presses_nxt   = presses_r;
    enroll_nxt    = enroll_r;
    next_slot_nxt = next_slot_r;
    valid_nxt     = valid_r;
    slot0_wr_nxt  = slot0_wr_r;
    store         = 1'b0;
    priority if (empty && key_kind == KEY_ENTER) begin
      presses_nxt = presses_inc;
      if (presses_inc == PRESS_ENROLL_ON) begin
        enroll_nxt = 1'b1;
      end else if (presses_inc == PRESS_ENROLL_OFF) begin
        enroll_nxt  = 1'b0;
        presses_nxt = '0;
      end
    end else if (key_kind == KEY_DIGIT && !full) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (count_r == CNT_W'(i)) begin
          entry_nxt[4*i +: 4] = key_digit;
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end else if (key_kind == KEY_CLEAR && !empty) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (key_kind == KEY_ENTER && full) begin
      if (enroll_r) begin
        store                 = 1'b1;
        valid_nxt[next_slot_r] = 1'b1;
        if (next_slot_r == '0) begin
          slot0_wr_nxt = 1'b1;
        end
        if (next_slot_r == SLOT_W'(CODE_SLOTS - 1)) begin
          next_slot_nxt = '0;
        end else begin
          next_slot_nxt = next_slot_r + SLOT_W'(1);
        end
      end
      count_nxt = '0;
    end else begin
      count_nxt = count_r;
    end
  end

  // Entry digits carry no reset; they are read only once fully written.
  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      presses_r   <= '0;
      enroll_r    <= 1'b0;
      blink_r     <= 1'b0;
      next_slot_r <= SLOT_W'(1);
      valid_r     <= CODE_SLOTS'(1);
      slot0_wr_r  <= 1'b0;
    end else if (take) begin
      count_r     <= count_nxt;
      presses_r   <= presses_nxt;
      enroll_r    <= enroll_nxt;
      blink_r     <= blink_nxt;
      next_slot_r <= next_slot_nxt;
      valid_r     <= valid_nxt;
      slot0_wr_r  <= slot0_wr_nxt;
    end
  end

  // Enrolled codes go straight into the code store.
  assign wr_en   = take && store;
  assign wr_addr = next_slot_r;
  assign wr_data = entry_r;

  assign step.led    = led;
  assign step.enroll = enroll_nxt;
  assign step.check  = (key_kind == KEY_ENTER) && full && !enroll_r;

  assign slots.entry         = entry_r;
  assign slots.valid         = valid_r;
  assign slots.slot0_written = slot0_wr_r;

endmodule

>>> src/kcl_scan.sv
// ----------------------------------------------------------------------------
// kcl_scan: sequencer, code store walk and result register
// Accepts items, walks every code slot through the RAM read port when an
// entry is checked, and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module kcl_scan import kcl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 take,
  input  kcl_step_t            step,
  input  kcl_slots_t           slots,
  output logic [SLOT_W-1:0]    rd_addr,
  input  logic [ENTRY_W-1:0]   rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LED_W-1:0]     out_led,
  output logic [VERDICT_W-1:0] out_verdict,
  output logic                 out_enroll_active
);

  kcl_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0]  idx_r;
  logic               cmp_vld_r;
  logic [SLOT_W-1:0]  cmp_idx_r;
  logic               hit_r;
  logic [LED_W-1:0]   res_led_r;
  logic               res_enroll_r;
  kcl_verdict_t       res_verdict_r;
  logic               out_valid_r;
  logic [LED_W-1:0]   out_led_r;
  kcl_verdict_t       out_verdict_r;
  logic               out_enroll_r;

  logic               last_idx;
  logic               load_out;
  logic [ENTRY_W-1:0] slot_code;
  logic               match;

  assign last_idx = (idx_r == SLOT_W'(CODE_SLOTS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = step.check ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
    rd_addr  = idx_r;
  end

  assign take = in_valid && in_ready;

  // Compare the slot read in the previous cycle; slot zero keeps its
  // factory code until enrollment overwrites it.
  assign slot_code = (cmp_idx_r == '0 && !slots.slot0_written) ? INIT_CODE : rd_data;
  assign match     = cmp_vld_r && slots.valid[cmp_idx_r] && (slot_code == slots.entry);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot walk and pending result.
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (take) begin
      idx_r         <= '0;
      hit_r         <= 1'b0;
      res_led_r     <= step.led;
      res_enroll_r  <= step.enroll;
      res_verdict_r <= VERDICT_NONE;
    end else begin
      if (state_r == ST_SCAN) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (cmp_vld_r) begin
        hit_r <= hit_r || match;
      end
      if (state_r == ST_LAST) begin
        res_verdict_r <= (hit_r || match) ? VERDICT_MATCH : VERDICT_REJECT;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_led_r     <= res_led_r;
      out_verdict_r <= res_verdict_r;
      out_enroll_r  <= res_enroll_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led           = out_led_r;
  assign out_verdict       = out_verdict_r;
  assign out_enroll_active = out_enroll_r;

  // The final compare always concerns the last slot.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAST |-> cmp_vld_r && cmp_idx_r == SLOT_W'(CODE_SLOTS - 1))
    else $error("final compare does not cover the last slot");

  // A verdict is only given outside enroll mode.
  a_verdict_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && res_verdict_r != VERDICT_NONE |-> !res_enroll_r)
    else $error("verdict given in enroll mode");

  // An accepted item starts a fresh walk.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r != ST_IDLE && !hit_r && idx_r == '0)
    else $error("slot walk not restarted on a new item");

  // A checked item leaves the walk with a decided verdict.
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAST |=> state_r == ST_DONE && res_verdict_r != VERDICT_NONE)
    else $error("slot walk ended without a verdict");

endmodule

>>> src/keypad_code_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_unit: keypad digital code lock
// Takes one keypad scan per item, keeps a code entry and enroll mode, and
// checks full entries against a RAM of stored codes.
//
//   channel | dir | payload                           | handshake
//   in_ch   | in  | buttons[11:0]                     | valid/ready
//   out_ch  | out | led[3:0], verdict[1:0], enroll    | valid/ready
//
// An item without a code check goes from ST_IDLE through ST_DONE into the
// output register; a code check first walks the code store in ST_SCAN at
// one RAM read per cycle, and ST_LAST decides the verdict before ST_DONE.
// A new item is accepted only in ST_IDLE, after the output register loads,
// so no item is taken before the last one is through. A result waiting
// in the output register does not block the input; a stalled sink holds the
// following result back. Synchronous active-low reset; no clearing pass,
// slot zero's factory code is supplied by logic until it is first written.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit import kcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  kcl_in_if.sink    in_ch,
  kcl_out_if.source out_ch
);

  logic               take;
  kcl_step_t          step;
  kcl_slots_t         slots;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // Entry buffer and mode bookkeeping.
  kcl_entry u_entry (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .buttons (in_ch.buttons),
    .step    (step),
    .slots   (slots),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Code store.
  kcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CODE_SLOTS)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, slot walk and output register.
  kcl_scan u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .take              (take),
    .step              (step),
    .slots             (slots),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_led           (out_ch.led),
    .out_verdict       (out_ch.verdict),
    .out_enroll_active (out_ch.enroll_active)
  );

endmodule
